[rtl/trd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, word types and control structs for the triangle raster block.
package trd_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH_BITS = 24;

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int DEPTH_W    = DEPTH_BITS;

  localparam int XY_W      = 16;
  localparam int ZIN_W     = 24;
  localparam int ID_W      = 16;
  localparam int PADDR_W   = 16;
  localparam int CNT_W     = 17;
  localparam int DIM_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam int SUB_BITS = 4;
  localparam int PIX_HALF = 8;
  localparam int BOX_W    = XY_W - SUB_BITS;
  localparam int EV_W     = XY_W + 1;
  localparam int DXY_W    = XY_W + 2;
  localparam int DZ_W     = ZIN_W + 1;

  localparam int MUL_A_W = DZ_W + 1;
  localparam int MUL_B_W = DXY_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int NRM_W   = EV_W + DZ_W + 2;
  localparam int NSPLIT  = NRM_W / 2;
  localparam int DEN_W   = 2 * EV_W + 2;
  localparam int EDGE_W  = DXY_W + EV_W + 5;
  localparam int NUM_W   = 64;
  localparam int QUO_W   = DEPTH_W + 2;
  localparam int DIV_W   = (DEN_W + QUO_W > NUM_W) ? DEN_W + QUO_W : NUM_W;
  localparam int QCNT_W  = $clog2(QUO_W);

  localparam logic [DIM_W-1:0] CFG_DIM_RESET = 9'd256;

  localparam logic signed [DEPTH_W-1:0] DEPTH_LOWEST  = {1'b1, {(DEPTH_W-1){1'b0}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_HIGHEST = {1'b0, {(DEPTH_W-1){1'b1}}};

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_DRAW   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam int MSTEP_W = 4;
  localparam logic [MSTEP_W-1:0] MS_NX_A   = 4'd0;
  localparam logic [MSTEP_W-1:0] MS_NX_B   = 4'd1;
  localparam logic [MSTEP_W-1:0] MS_NY_A   = 4'd2;
  localparam logic [MSTEP_W-1:0] MS_NY_B   = 4'd3;
  localparam logic [MSTEP_W-1:0] MS_NZ_A   = 4'd4;
  localparam logic [MSTEP_W-1:0] MS_NZ_B   = 4'd5;
  localparam logic [MSTEP_W-1:0] MS_E1_A   = 4'd6;
  localparam logic [MSTEP_W-1:0] MS_E1_B   = 4'd7;
  localparam logic [MSTEP_W-1:0] MS_E2_A   = 4'd8;
  localparam logic [MSTEP_W-1:0] MS_E2_B   = 4'd9;
  localparam logic [MSTEP_W-1:0] MS_E3_A   = 4'd10;
  localparam logic [MSTEP_W-1:0] MS_E3_B   = 4'd11;
  localparam logic [MSTEP_W-1:0] MS_NUM_XL = 4'd12;
  localparam logic [MSTEP_W-1:0] MS_NUM_XH = 4'd13;
  localparam logic [MSTEP_W-1:0] MS_NUM_YL = 4'd14;
  localparam logic [MSTEP_W-1:0] MS_NUM_YH = 4'd15;

  localparam int RES_OP_W = 3;
  localparam logic [RES_OP_W-1:0] RES_HOLD  = 3'd0;
  localparam logic [RES_OP_W-1:0] RES_ZERO  = 3'd1;
  localparam logic [RES_OP_W-1:0] RES_DEGEN = 3'd2;
  localparam logic [RES_OP_W-1:0] RES_DRAW  = 3'd3;
  localparam logic [RES_OP_W-1:0] RES_READ  = 3'd4;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [XY_W-1:0]    vert0_x;
    logic signed [XY_W-1:0]    vert0_y;
    logic signed [ZIN_W-1:0]   vert0_z;
    logic signed [XY_W-1:0]    vert1_x;
    logic signed [XY_W-1:0]    vert1_y;
    logic signed [ZIN_W-1:0]   vert1_z;
    logic signed [XY_W-1:0]    vert2_x;
    logic signed [XY_W-1:0]    vert2_y;
    logic signed [ZIN_W-1:0]   vert2_z;
    logic [ID_W-1:0]           triangle_id;
    logic [PADDR_W-1:0]        pixel_addr;
  } req_word_t;

  typedef struct packed {
    logic signed [ZIN_W-1:0] read_depth;
    logic [ID_W-1:0]         read_id;
    logic                    read_covered;
    logic [CNT_W-1:0]        pixels_written;
    logic                    degenerate;
  } res_word_t;

  typedef struct packed {
    logic                load;
    logic                clr_en;
    logic                mul_en;
    logic [MSTEP_W-1:0]  mul_step;
    logic                pix_init;
    logic                step_x;
    logic                step_y;
    logic                rd_pix;
    logic                rd_req;
    logic                div_start;
    logic                commit;
    logic [RES_OP_W-1:0] res_op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic degen;
    logic box_empty;
    logic in_tri;
    logic last_x;
    logic last_y;
    logic div_done;
  } sts_t;

endpackage

[rtl/trd_req_if.sv]
`timescale 1ns / 1ps
// Request channel: valid, ready and one request word.
interface trd_req_if;
  logic                valid;
  logic                ready;
  trd_pkg::req_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/trd_res_if.sv]
`timescale 1ns / 1ps
// Result channel: valid, ready and one result word.
interface trd_res_if;
  logic                valid;
  logic                ready;
  trd_pkg::res_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/triangle_raster_depth_buffer.sv]
`timescale 1ns / 1ps
// Top level: triangle rasterizer with depth, id and covered stores.
//
//   channel | dir | handshake       | word
//   req     | in  | valid / ready   | req_word_t (type, three vertices, id, pixel address)
//   res     | out | valid / ready   | res_word_t (read fields, pixel count, degenerate flag)
//   cfg     | in  | cfg_we          | cfg_idx selects width or height, cfg_data value
//
// One request at a time; ready is high only while idle and no result is pending.
// After reset a clearing pass runs before the first request is taken.
// Clear: one store entry per cycle. Read: stores read, then the result word is formed.
// Draw: plane setup on the shared multiplier, then per box pixel an edge test; inside
// pixels also wait for the 26-step serial depth divider before the depth test.
// A result holds on the output until taken; configuration writes are taken at any time.
module triangle_raster_depth_buffer (
  input  logic                          clk,
  input  logic                          rst,
  trd_req_if.sink                       req,
  trd_res_if.source                     res,
  input  logic                          cfg_we,
  input  logic [trd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [trd_pkg::DIM_W-1:0]     cfg_data
);
  import trd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  trd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.data.req_type),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  trd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req_data (req.data),
    .cmd      (cmd),
    .sts      (sts),
    .res_data (res.data)
  );
endmodule

[rtl/trd_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module trd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[rtl/trd_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with saturation detect.
module trd_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [trd_pkg::NUM_W-1:0]  num,
  input  logic signed [trd_pkg::DEN_W-1:0]  den,
  output logic                              done,
  output logic                              ovf,
  output logic                              neg,
  output logic [trd_pkg::QUO_W-1:0]         qmag
);
  import trd_pkg::*;

  logic [DIV_W-1:0]  num_abs;
  logic [DIV_W-1:0]  den_abs;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsh;
  logic [QCNT_W-1:0] cnt;
  logic              busy;
  logic              ge;

  assign num_abs = num[NUM_W-1] ? DIV_W'(-num) : DIV_W'(num);
  assign den_abs = den[DEN_W-1] ? DIV_W'(-den) : DIV_W'(den);
  assign ge      = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num_abs;
      dsh  <= den_abs << (QUO_W - 1);
      ovf  <= num_abs >= (den_abs << QUO_W);
      neg  <= num[NUM_W-1] ^ den[DEN_W-1];
      cnt  <= QCNT_W'(QUO_W - 1);
      qmag <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      qmag <= {qmag[QUO_W-2:0], ge};
      dsh  <= dsh >> 1;
      cnt  <= cnt - 1'b1;
    end
  end
endmodule

[rtl/trd_datapath.sv]
`timescale 1ns / 1ps
// Datapath: plane setup, edge stepping, depth division, stores and result word.
module trd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [trd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [trd_pkg::DIM_W-1:0]     cfg_data,
  input  trd_pkg::req_word_t            req_data,
  input  trd_pkg::cmd_t                 cmd,
  output trd_pkg::sts_t                 sts,
  output trd_pkg::res_word_t            res_data
);
  import trd_pkg::*;

  function automatic logic signed [XY_W-1:0] min3(input logic signed [XY_W-1:0] a,
                                                  input logic signed [XY_W-1:0] b,
                                                  input logic signed [XY_W-1:0] c);
    logic signed [XY_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [XY_W-1:0] max3(input logic signed [XY_W-1:0] a,
                                                  input logic signed [XY_W-1:0] b,
                                                  input logic signed [XY_W-1:0] c);
    logic signed [XY_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  logic [DIM_W-1:0] width_cfg;
  logic [DIM_W-1:0] height_cfg;
  logic [DIM_W-1:0] wc;
  logic [DIM_W-1:0] hc;
  req_word_t        word;

  logic signed [EV_W-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [EV_W-1:0] ax, ay, bx, by, cx, cy;
  logic signed [DZ_W-1:0] bz, cz;

  logic signed [XY_W:0] lo_x, lo_y, hi_x, hi_y;
  logic [BOX_W-1:0]     minx, miny, maxx, maxy, hr_x, hr_y, lim_x, lim_y;
  logic [XY_W-1:0]      px0, py0;
  logic signed [DXY_W-1:0] dpx0, dpx1, dpx2, dpy0, dpy1, dpy2;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic [MSTEP_W-1:0]        pstep;
  logic                      pval;

  logic signed [NRM_W-1:0]   nx, ny;
  logic signed [DEN_W-1:0]   nz;
  logic signed [EDGE_W-1:0]  e1, e2, e3, ec1, ec2, ec3;
  logic signed [NUM_W-1:0]   num, nc;
  logic signed [MUL_A_W-1:0] nx_lo, nx_hi, ny_lo, ny_hi;
  logic signed [EDGE_W-1:0]  dex1, dex2, dex3, dey1, dey2, dey3;
  logic signed [NUM_W-1:0]   dnx, dny;

  logic [BOX_W-1:0]           cur_x, cur_y;
  logic [BOX_W+DIM_W-1:0]     pix_lin;
  logic [ADDR_W-1:0]          pix_addr;
  logic                       pos, neg_s;

  logic                       div_done, q_ovf, q_neg;
  logic [QUO_W-1:0]           q_mag;
  logic signed [QUO_W:0]      q_s;
  logic signed [DEPTH_W+3:0]  zw;
  logic signed [DEPTH_W-1:0]  zsat;
  logic                       pass, wr_pix;

  logic [ADDR_W-1:0]          clr_addr;
  logic                       clr_last;
  logic [CNT_W-1:0]           count;

  logic [ADDR_W-1:0]          rd_addr, wr_addr;
  logic [DEPTH_W-1:0]         depth_rd;
  logic [ID_W-1:0]            id_rd;
  logic                       cov_rd;
  logic [2*DIM_W-1:0]         area;
  logic                       in_range;
  res_word_t                  res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= CFG_DIM_RESET;
      height_cfg <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_WIDTH) begin
        width_cfg <= cfg_data;
      end else begin
        height_cfg <= cfg_data;
      end
    end
  end

  assign wc = (width_cfg == '0) ? DIM_W'(1) :
              (width_cfg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_cfg;
  assign hc = (height_cfg == '0) ? DIM_W'(1) :
              (height_cfg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_cfg;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= req_data;
    end
  end

  assign x0 = EV_W'(word.vert0_x);
  assign y0 = EV_W'(word.vert0_y);
  assign x1 = EV_W'(word.vert1_x);
  assign y1 = EV_W'(word.vert1_y);
  assign x2 = EV_W'(word.vert2_x);
  assign y2 = EV_W'(word.vert2_y);

  assign ax = x0 - x2;
  assign ay = y0 - y2;
  assign bx = x2 - x1;
  assign by = y2 - y1;
  assign cx = x1 - x0;
  assign cy = y1 - y0;
  assign bz = DZ_W'(word.vert2_z) - DZ_W'(word.vert1_z);
  assign cz = DZ_W'(word.vert1_z) - DZ_W'(word.vert0_z);

  assign lo_x = (XY_W+1)'(min3(word.vert0_x, word.vert1_x, word.vert2_x)) + (XY_W+1)'(PIX_HALF);
  assign lo_y = (XY_W+1)'(min3(word.vert0_y, word.vert1_y, word.vert2_y)) + (XY_W+1)'(PIX_HALF);
  assign hi_x = (XY_W+1)'(max3(word.vert0_x, word.vert1_x, word.vert2_x)) - (XY_W+1)'(PIX_HALF);
  assign hi_y = (XY_W+1)'(max3(word.vert0_y, word.vert1_y, word.vert2_y)) - (XY_W+1)'(PIX_HALF);

  assign minx  = lo_x[XY_W] ? '0 : lo_x[XY_W-1:SUB_BITS];
  assign miny  = lo_y[XY_W] ? '0 : lo_y[XY_W-1:SUB_BITS];
  assign hr_x  = hi_x[XY_W] ? '0 : hi_x[XY_W-1:SUB_BITS];
  assign hr_y  = hi_y[XY_W] ? '0 : hi_y[XY_W-1:SUB_BITS];
  assign lim_x = BOX_W'(wc - 1'b1);
  assign lim_y = BOX_W'(hc - 1'b1);
  assign maxx  = (hr_x > lim_x) ? lim_x : hr_x;
  assign maxy  = (hr_y > lim_y) ? lim_y : hr_y;

  assign px0  = {minx, SUB_BITS'(PIX_HALF)};
  assign py0  = {miny, SUB_BITS'(PIX_HALF)};
  assign dpx0 = $signed({2'b00, px0}) - DXY_W'(x0);
  assign dpx1 = $signed({2'b00, px0}) - DXY_W'(x1);
  assign dpx2 = $signed({2'b00, px0}) - DXY_W'(x2);
  assign dpy0 = $signed({2'b00, py0}) - DXY_W'(y0);
  assign dpy1 = $signed({2'b00, py0}) - DXY_W'(y1);
  assign dpy2 = $signed({2'b00, py0}) - DXY_W'(y2);

  assign nx_lo = $signed({{(MUL_A_W-NSPLIT){1'b0}}, nx[NSPLIT-1:0]});
  assign nx_hi = MUL_A_W'($signed(nx[NRM_W-1:NSPLIT]));
  assign ny_lo = $signed({{(MUL_A_W-NSPLIT){1'b0}}, ny[NSPLIT-1:0]});
  assign ny_hi = MUL_A_W'($signed(ny[NRM_W-1:NSPLIT]));

  always_comb begin
    unique case (cmd.mul_step)
      MS_NX_A:   begin mul_a = MUL_A_W'(bz);  mul_b = MUL_B_W'(cy); end
      MS_NX_B:   begin mul_a = MUL_A_W'(cz);  mul_b = MUL_B_W'(by); end
      MS_NY_A:   begin mul_a = MUL_A_W'(cz);  mul_b = MUL_B_W'(bx); end
      MS_NY_B:   begin mul_a = MUL_A_W'(bz);  mul_b = MUL_B_W'(cx); end
      MS_NZ_A:   begin mul_a = MUL_A_W'(by);  mul_b = MUL_B_W'(cx); end
      MS_NZ_B:   begin mul_a = MUL_A_W'(bx);  mul_b = MUL_B_W'(cy); end
      MS_E1_A:   begin mul_a = MUL_A_W'(ay);  mul_b = dpx2; end
      MS_E1_B:   begin mul_a = MUL_A_W'(ax);  mul_b = dpy2; end
      MS_E2_A:   begin mul_a = MUL_A_W'(by);  mul_b = dpx1; end
      MS_E2_B:   begin mul_a = MUL_A_W'(bx);  mul_b = dpy1; end
      MS_E3_A:   begin mul_a = MUL_A_W'(cy);  mul_b = dpx0; end
      MS_E3_B:   begin mul_a = MUL_A_W'(cx);  mul_b = dpy0; end
      MS_NUM_XL: begin mul_a = nx_lo;         mul_b = dpx0; end
      MS_NUM_XH: begin mul_a = nx_hi;         mul_b = dpx0; end
      MS_NUM_YL: begin mul_a = ny_lo;         mul_b = dpy0; end
      MS_NUM_YH: begin mul_a = ny_hi;         mul_b = dpy0; end
      default:   begin mul_a = '0;            mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pval <= 1'b0;
    end else begin
      pval <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod  <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    pstep <= cmd.mul_step;
  end

  assign dex1 = EDGE_W'(ay) <<< SUB_BITS;
  assign dex2 = EDGE_W'(by) <<< SUB_BITS;
  assign dex3 = EDGE_W'(cy) <<< SUB_BITS;
  assign dey1 = -(EDGE_W'(ax) <<< SUB_BITS);
  assign dey2 = -(EDGE_W'(bx) <<< SUB_BITS);
  assign dey3 = -(EDGE_W'(cx) <<< SUB_BITS);
  assign dnx  = NUM_W'(nx) <<< SUB_BITS;
  assign dny  = NUM_W'(ny) <<< SUB_BITS;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nx  <= '0;
      ny  <= '0;
      nz  <= '0;
      e1  <= '0;
      e2  <= '0;
      e3  <= '0;
      num <= '0;
    end else if (pval) begin
      unique case (pstep)
        MS_NX_A:   nx  <= nx + NRM_W'(prod);
        MS_NX_B:   nx  <= nx - NRM_W'(prod);
        MS_NY_A:   ny  <= ny + NRM_W'(prod);
        MS_NY_B:   ny  <= ny - NRM_W'(prod);
        MS_NZ_A:   nz  <= nz + DEN_W'(prod);
        MS_NZ_B:   nz  <= nz - DEN_W'(prod);
        MS_E1_A:   e1  <= e1 + EDGE_W'(prod);
        MS_E1_B:   e1  <= e1 - EDGE_W'(prod);
        MS_E2_A:   e2  <= e2 + EDGE_W'(prod);
        MS_E2_B:   e2  <= e2 - EDGE_W'(prod);
        MS_E3_A:   e3  <= e3 + EDGE_W'(prod);
        MS_E3_B:   e3  <= e3 - EDGE_W'(prod);
        MS_NUM_XL: num <= num + NUM_W'(prod);
        MS_NUM_XH: num <= num + (NUM_W'(prod) <<< NSPLIT);
        MS_NUM_YL: num <= num + NUM_W'(prod);
        MS_NUM_YH: num <= num + (NUM_W'(prod) <<< NSPLIT);
        default:   num <= num;
      endcase
    end else if (cmd.step_y) begin
      e1  <= e1 + dey1;
      e2  <= e2 + dey2;
      e3  <= e3 + dey3;
      num <= num + dny;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_init) begin
      cur_x <= minx;
      cur_y <= miny;
      ec1   <= e1;
      ec2   <= e2;
      ec3   <= e3;
      nc    <= num;
    end else if (cmd.step_y) begin
      cur_x <= minx;
      cur_y <= cur_y + 1'b1;
      ec1   <= e1 + dey1;
      ec2   <= e2 + dey2;
      ec3   <= e3 + dey3;
      nc    <= num + dny;
    end else if (cmd.step_x) begin
      cur_x <= cur_x + 1'b1;
      ec1   <= ec1 + dex1;
      ec2   <= ec2 + dex2;
      ec3   <= ec3 + dex3;
      nc    <= nc + dnx;
    end
  end

  assign pix_lin  = (BOX_W+DIM_W)'(cur_y) * (BOX_W+DIM_W)'(wc) + (BOX_W+DIM_W)'(cur_x);
  assign pix_addr = pix_lin[ADDR_W-1:0];

  assign pos   = (ec1 > 0) || (ec2 > 0) || (ec3 > 0);
  assign neg_s = (ec1 < 0) || (ec2 < 0) || (ec3 < 0);

  trd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (nc),
    .den   (nz),
    .done  (div_done),
    .ovf   (q_ovf),
    .neg   (q_neg),
    .qmag  (q_mag)
  );

  assign q_s = q_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign zw  = (DEPTH_W+4)'(word.vert0_z) - (DEPTH_W+4)'(q_s);

  always_comb begin
    if (q_ovf) begin
      zsat = q_neg ? DEPTH_HIGHEST : DEPTH_LOWEST;
    end else if (zw < (DEPTH_W+4)'(DEPTH_LOWEST)) begin
      zsat = DEPTH_LOWEST;
    end else if (zw > (DEPTH_W+4)'(DEPTH_HIGHEST)) begin
      zsat = DEPTH_HIGHEST;
    end else begin
      zsat = zw[DEPTH_W-1:0];
    end
  end

  assign pass   = zsat >= $signed(depth_rd);
  assign wr_pix = cmd.commit && pass;

  assign clr_last = clr_addr == ADDR_W'(STORE_SIZE - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count <= '0;
    end else if (wr_pix) begin
      count <= count + 1'b1;
    end
  end

  assign wr_addr = cmd.clr_en ? clr_addr : pix_addr;
  assign rd_addr = cmd.rd_pix ? pix_addr : ADDR_W'(word.pixel_addr);

  trd_ram #(.WIDTH(DEPTH_W), .DEPTH(STORE_SIZE)) u_depth_ram (
    .clk     (clk),
    .we      (cmd.clr_en || wr_pix),
    .wr_addr (wr_addr),
    .wr_data (cmd.clr_en ? DEPTH_LOWEST : zsat),
    .rd_en   (cmd.rd_pix || cmd.rd_req),
    .rd_addr (rd_addr),
    .rd_data (depth_rd)
  );

  trd_ram #(.WIDTH(ID_W), .DEPTH(STORE_SIZE)) u_id_ram (
    .clk     (clk),
    .we      (wr_pix),
    .wr_addr (pix_addr),
    .wr_data (word.triangle_id),
    .rd_en   (cmd.rd_req),
    .rd_addr (rd_addr),
    .rd_data (id_rd)
  );

  trd_ram #(.WIDTH(1), .DEPTH(STORE_SIZE)) u_cov_ram (
    .clk     (clk),
    .we      (cmd.clr_en || wr_pix),
    .wr_addr (wr_addr),
    .wr_data (!cmd.clr_en),
    .rd_en   (cmd.rd_req),
    .rd_addr (rd_addr),
    .rd_data (cov_rd)
  );

  assign area     = (2*DIM_W)'(wc) * (2*DIM_W)'(hc);
  assign in_range = (2*DIM_W)'(word.pixel_addr) < area;

  always_comb begin
    res_next = res_data;
    unique case (cmd.res_op)
      RES_ZERO: res_next = '0;
      RES_DEGEN: begin
        res_next            = '0;
        res_next.degenerate = 1'b1;
      end
      RES_DRAW: begin
        res_next                = '0;
        res_next.pixels_written = count;
      end
      RES_READ: begin
        res_next              = '0;
        res_next.read_depth   = in_range ? ZIN_W'($signed(depth_rd)) : '0;
        res_next.read_covered = in_range && cov_rd;
        res_next.read_id      = (in_range && cov_rd) ? id_rd : '0;
      end
      default: res_next = res_data;
    endcase
  end

  always_ff @(posedge clk) begin
    res_data <= res_next;
  end

  assign sts.clr_last  = clr_last;
  assign sts.degen     = nz == '0;
  assign sts.box_empty = (minx > maxx) || (miny > maxy);
  assign sts.in_tri    = !(pos && neg_s);
  assign sts.last_x    = cur_x == maxx;
  assign sts.last_y    = cur_y == maxy;
  assign sts.div_done  = div_done;
endmodule

[rtl/trd_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences clear, draw setup, pixel sweep and read.
module trd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [1:0]    req_type,
  output logic          req_ready,
  output logic          res_valid,
  input  logic          res_ready,
  input  trd_pkg::sts_t sts,
  output trd_pkg::cmd_t cmd
);
  import trd_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_PIX   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_TEST  = 4'd8;
  localparam logic [3:0] S_ADV   = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_RDATA = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]         state, state_next;
  logic [MSTEP_W-1:0] mstep, mstep_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      mstep <= '0;
    end else begin
      state <= state_next;
      mstep <= mstep_next;
    end
  end

  assign req_ready = state == S_IDLE;
  assign res_valid = state == S_DONE;

  always_comb begin
    state_next   = state;
    mstep_next   = mstep;
    cmd          = '0;
    cmd.mul_step = mstep;
    unique case (state)
      S_INIT: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          case (req_type)
            REQ_CLEAR: state_next = S_CLEAR;
            REQ_DRAW: begin
              state_next = S_SETUP;
              mstep_next = '0;
            end
            REQ_READ: state_next = S_RD;
            default: begin
              cmd.res_op = RES_ZERO;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          cmd.res_op = RES_ZERO;
          state_next = S_DONE;
        end
      end
      S_SETUP: begin
        cmd.mul_en = 1'b1;
        if (mstep == MS_NUM_YH) begin
          state_next = S_DRAIN;
        end else begin
          mstep_next = mstep + 1'b1;
        end
      end
      S_DRAIN: state_next = S_CHECK;
      S_CHECK: begin
        if (sts.degen) begin
          cmd.res_op = RES_DEGEN;
          state_next = S_DONE;
        end else if (sts.box_empty) begin
          cmd.res_op = RES_DRAW;
          state_next = S_DONE;
        end else begin
          cmd.pix_init = 1'b1;
          state_next   = S_PIX;
        end
      end
      S_PIX: begin
        if (sts.in_tri) begin
          cmd.rd_pix    = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_ADV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        cmd.commit = 1'b1;
        state_next = S_ADV;
      end
      S_ADV: begin
        if (sts.last_x && sts.last_y) begin
          cmd.res_op = RES_DRAW;
          state_next = S_DONE;
        end else if (sts.last_x) begin
          cmd.step_y = 1'b1;
          state_next = S_PIX;
        end else begin
          cmd.step_x = 1'b1;
          state_next = S_PIX;
        end
      end
      S_RD: begin
        cmd.rd_req = 1'b1;
        state_next = S_RDATA;
      end
      S_RDATA: begin
        cmd.res_op = RES_READ;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the triangle rasterizer with depth, id and covered stores.
module tb_top;
  import trd_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int HOLD_CYCLES = 400;
  localparam int REQ_W = $bits(req_word_t);

  typedef struct {
    logic [1:0] kind;
    int x0, y0, z0, x1, y1, z1, x2, y2, z2;
    int tri_id, addr;
    bit typed;
    res_word_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  trd_req_if req ();
  trd_res_if res ();

  triangle_raster_depth_buffer dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  logic signed [DEPTH_W-1:0] px_depth [STORE_SIZE];
  logic [ID_W-1:0] px_id [STORE_SIZE];
  bit px_cov [STORE_SIZE];
  int frame_w = 256, frame_h = 256;

  res_word_t pending_res [$];
  int errors = 0;
  int words_sent = 0;
  int cycles = 0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int send_idle_pct();
    if (words_sent < 193) return 25;
    if (words_sent < 386) return 65;
    return 0;
  endfunction

  function automatic int take_idle_pct();
    if (words_sent < 193) return 65;
    if (words_sent < 386) return 25;
    return 0;
  endfunction

  function automatic int box_lo(longint v);
    v += PIX_HALF;
    return (v < 0) ? 0 : int'(v / 16);
  endfunction

  function automatic int box_hi(longint v, int lim);
    int r;
    v -= PIX_HALF;
    r = (v < 0) ? 0 : int'(v / 16);
    return (r > lim - 1) ? lim - 1 : r;
  endfunction

  function automatic res_word_t raster_predict(req_word_t q);
    res_word_t r;
    longint x0, y0, z0, x1, y1, z1, x2, y2, z2;
    longint ax, ay, bx, by, bz, cx, cy, cz, nx, ny, nz;
    longint pxc, pyc, s1, s2, s3, z;
    int minx, miny, maxx, maxy, p, cnt;
    bit pos, neg;
    r = '0;
    cnt = 0;
    case (q.req_type)
      REQ_CLEAR: begin
        for (int i = 0; i < STORE_SIZE; i++) begin
          px_depth[i] = DEPTH_LOWEST;
          px_cov[i] = 1'b0;
        end
      end
      REQ_DRAW: begin
        x0 = q.vert0_x; y0 = q.vert0_y; z0 = q.vert0_z;
        x1 = q.vert1_x; y1 = q.vert1_y; z1 = q.vert1_z;
        x2 = q.vert2_x; y2 = q.vert2_y; z2 = q.vert2_z;
        ax = x0 - x2; ay = y0 - y2;
        bx = x2 - x1; by = y2 - y1; bz = z2 - z1;
        cx = x1 - x0; cy = y1 - y0; cz = z1 - z0;
        nx = cy * bz - cz * by;
        ny = cz * bx - cx * bz;
        nz = cx * by - cy * bx;
        if (nz == 0) begin
          r.degenerate = 1'b1;
          return r;
        end
        minx = box_lo((x0 < x1) ? ((x0 < x2) ? x0 : x2) : ((x1 < x2) ? x1 : x2));
        miny = box_lo((y0 < y1) ? ((y0 < y2) ? y0 : y2) : ((y1 < y2) ? y1 : y2));
        maxx = box_hi((x0 > x1) ? ((x0 > x2) ? x0 : x2) : ((x1 > x2) ? x1 : x2), frame_w);
        maxy = box_hi((y0 > y1) ? ((y0 > y2) ? y0 : y2) : ((y1 > y2) ? y1 : y2), frame_h);
        for (int y = miny; y <= maxy; y++) begin
          for (int x = minx; x <= maxx; x++) begin
            pxc = longint'(x) * 16 + PIX_HALF;
            pyc = longint'(y) * 16 + PIX_HALF;
            s1 = (pxc - x2) * ay - (pyc - y2) * ax;
            s2 = (pxc - x1) * by - (pyc - y1) * bx;
            s3 = (pxc - x0) * cy - (pyc - y0) * cx;
            pos = (s1 > 0) || (s2 > 0) || (s3 > 0);
            neg = (s1 < 0) || (s2 < 0) || (s3 < 0);
            if (pos && neg) continue;
            z = z0 - (nx * (pxc - x0) + ny * (pyc - y0)) / nz;
            if (z < longint'(DEPTH_LOWEST)) z = DEPTH_LOWEST;
            if (z > longint'(DEPTH_HIGHEST)) z = DEPTH_HIGHEST;
            p = y * frame_w + x;
            if (z < longint'(px_depth[p])) continue;
            px_depth[p] = z[DEPTH_W-1:0];
            px_id[p] = q.triangle_id;
            px_cov[p] = 1'b1;
            cnt++;
          end
        end
        r.pixels_written = CNT_W'(cnt);
      end
      REQ_READ: begin
        if (int'(q.pixel_addr) < frame_w * frame_h) begin
          r.read_depth = px_depth[q.pixel_addr];
          r.read_id = px_cov[q.pixel_addr] ? px_id[q.pixel_addr] : '0;
          r.read_covered = px_cov[q.pixel_addr];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_sent >= 50) begin
      res.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= take_idle_pct());
    end
  end

  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_res.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        want = pending_res.pop_front();
        if (res.data.read_depth !== want.read_depth)
          report("read_depth", res.data.read_depth, want.read_depth);
        if (res.data.read_id !== want.read_id)
          report("read_id", res.data.read_id, want.read_id);
        if (res.data.read_covered !== want.read_covered)
          report("read_covered", res.data.read_covered, want.read_covered);
        if (res.data.pixels_written !== want.pixels_written)
          report("pixels_written", res.data.pixels_written, want.pixels_written);
        if (res.data.degenerate !== want.degenerate)
          report("degenerate", res.data.degenerate, want.degenerate);
      end
    end
  end

  task automatic push_word(req_word_t w, bit typed, res_word_t typed_res);
    res_word_t pred;
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pred = raster_predict(w);
    if (typed && pred !== typed_res) report("typed row disagrees with predictor", 0, 0);
    pending_res.push_back(typed ? typed_res : pred);
    words_sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_WIDTH;
    cfg_data <= w[DIM_W-1:0];
    @(posedge clk);
    cfg_idx <= CFG_HEIGHT;
    cfg_data <= h[DIM_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    frame_w = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    frame_h = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  function automatic req_word_t random_word();
    req_word_t w;
    int roll, cx, cy, cz;
    w = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    roll = $urandom_range(0, 99);
    if (roll < 1) begin
      w.req_type = REQ_CLEAR;
    end else if (roll < 3) begin
      w.req_type = REQ_UNUSED;
    end else if (roll < 35) begin
      w.req_type = REQ_READ;
      if ($urandom_range(0, 9) != 0)
        w.pixel_addr = PADDR_W'($urandom_range(0, frame_w * frame_h - 1));
    end else begin
      w.req_type = REQ_DRAW;
      if (frame_w * frame_h > 1024 || $urandom_range(0, 9) != 0) begin
        cx = $urandom_range(0, frame_w * 16 + 32) - 16;
        cy = $urandom_range(0, frame_h * 16 + 32) - 16;
        cz = $urandom_range(0, 8000) - 4000;
        w.vert0_x = XY_W'(cx + int'($urandom_range(0, 96)) - 48);
        w.vert0_y = XY_W'(cy + int'($urandom_range(0, 96)) - 48);
        w.vert1_x = XY_W'(cx + int'($urandom_range(0, 96)) - 48);
        w.vert1_y = XY_W'(cy + int'($urandom_range(0, 96)) - 48);
        w.vert2_x = XY_W'(cx + int'($urandom_range(0, 96)) - 48);
        w.vert2_y = XY_W'(cy + int'($urandom_range(0, 96)) - 48);
        if ($urandom_range(0, 1)) begin
          w.vert0_z = ZIN_W'(cz + int'($urandom_range(0, 2000)) - 1000);
          w.vert1_z = ZIN_W'(cz + int'($urandom_range(0, 2000)) - 1000);
          w.vert2_z = ZIN_W'(cz + int'($urandom_range(0, 2000)) - 1000);
        end
        if ($urandom_range(0, 19) == 0) w.vert2_x = w.vert1_x;
        if ($urandom_range(0, 19) == 0) begin
          w.vert1_x = w.vert0_x;
          w.vert2_x = w.vert0_x;
        end
      end
    end
    return w;
  endfunction

  dir_row_t dir_tab [] = '{
    '{REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 0}},
    '{REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '{DEPTH_LOWEST, 0, 0, 0, 0}},
    '{REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255, 1'b1, '{DEPTH_LOWEST, 0, 0, 0, 0}},
    '{REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 256, 1'b1, '{0, 0, 0, 0, 0}},
    '{REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 1'b1, '{0, 0, 0, 0, 0}},
    '{REQ_UNUSED, 5, 5, 5, 5, 5, 5, 5, 5, 5, 7, 3, 1'b1, '{0, 0, 0, 0, 0}},
    '{REQ_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9, 0, 1'b1, '{0, 0, 0, 0, 1}},
    '{REQ_DRAW, 0, 0, 5, 32, 32, 9, 64, 64, 1, 9, 0, 1'b1, '{0, 0, 0, 0, 1}},
    '{REQ_DRAW, 8, 8, 256, 72, 8, 512, 8, 72, 768, 11, 0, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_DRAW, 8, 8, 256, 8, 72, 768, 72, 8, 512, 12, 0, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 17, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_DRAW, 8, 8, 100, 72, 8, 100, 8, 72, 100, 13, 0, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_DRAW, -32768, -32768, -8388608, 32767, -32768, 8388607, -32768, 32767, 8388607,
      65535, 0, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_DRAW, 32767, 32767, 8388607, -32768, 32767, -8388608, 32767, -32768, 0,
      0, 0, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_DRAW, -100, -100, 50, -50, -100, 60, -100, -50, 70, 21, 0, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 34, 1'b0, '{0, 0, 0, 0, 0}},
    '{REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 0}},
    '{REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 100, 1'b1, '{DEPTH_LOWEST, 0, 0, 0, 0}}
  };

  int phase_dims [6][2] = '{'{256, 256}, '{0, 0}, '{511, 7}, '{1, 256}, '{33, 20}, '{16, 511}};

  initial begin
    req_word_t w;
    res_word_t none;
    none = '0;
    req.valid = 1'b0;
    req.data = '0;
    res.ready = 1'b0;
    for (int i = 0; i < STORE_SIZE; i++) begin
      px_depth[i] = '0;
      px_id[i] = '0;
      px_cov[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_frame(16, 16);
    foreach (dir_tab[i]) begin
      w = '0;
      w.req_type = dir_tab[i].kind;
      w.vert0_x = XY_W'(dir_tab[i].x0);
      w.vert0_y = XY_W'(dir_tab[i].y0);
      w.vert0_z = ZIN_W'(dir_tab[i].z0);
      w.vert1_x = XY_W'(dir_tab[i].x1);
      w.vert1_y = XY_W'(dir_tab[i].y1);
      w.vert1_z = ZIN_W'(dir_tab[i].z1);
      w.vert2_x = XY_W'(dir_tab[i].x2);
      w.vert2_y = XY_W'(dir_tab[i].y2);
      w.vert2_z = ZIN_W'(dir_tab[i].z2);
      w.triangle_id = ID_W'(dir_tab[i].tri_id);
      w.pixel_addr = PADDR_W'(dir_tab[i].addr);
      push_word(w, dir_tab[i].typed, dir_tab[i].want);
    end
    for (int ph = 0; ph < 6; ph++) begin
      set_frame(phase_dims[ph][0], phase_dims[ph][1]);
      repeat (97) push_word(random_word(), 1'b0, none);
    end
    req.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/trd_pkg.sv
rtl/trd_req_if.sv
rtl/trd_res_if.sv
rtl/trd_ram.sv
rtl/trd_div.sv
rtl/trd_datapath.sv
rtl/trd_ctrl.sv
rtl/triangle_raster_depth_buffer.sv
tb/tb_top.sv
